// ===== sv/ipu_pkg.sv =====
// ----------------------------------------------------------------------------
// ipu_pkg
// Shared types and constants for the integer pixel upscaler.
// ----------------------------------------------------------------------------
package ipu_pkg;

	localparam int PIX_W  = 24;
	localparam int FACT_W = 7;
	localparam int LEN_W  = 11;
	localparam int PAD_W  = 2;
	localparam int APB_AW = 4;
	localparam int APB_DW = 32;

	// Register map, word index taken from paddr[3:2]
	typedef enum logic [1:0] {
		REG_SCALE = 2'd0,
		REG_WIDTH = 2'd1,
		REG_ROWS  = 2'd2
	} reg_idx_t;

	typedef enum logic {
		REQ_PIXEL = 1'b0,
		REQ_PULL  = 1'b1
	} req_t;

	typedef enum logic {
		KIND_PIXEL   = 1'b0,
		KIND_REFUSED = 1'b1
	} kind_t;

	// Effective (clamped) configuration plus the restart strobe
	typedef struct packed {
		logic [FACT_W-1:0] factor;
		logic [LEN_W-1:0]  width;
		logic [LEN_W-1:0]  rows;
		logic [PAD_W-1:0]  pad;
		logic              restart;
	} cfg_t;

endpackage

// ===== sv/ipu_if.sv =====
// ----------------------------------------------------------------------------
// ipu_in_if / ipu_out_if
// Valid/ready channels for request beats and result beats.
// ----------------------------------------------------------------------------
interface ipu_in_if;
	logic        valid;
	logic        ready;
	logic        req_type;
	logic [23:0] pixel_in;

	modport source (output valid, output req_type, output pixel_in, input ready);
	modport sink   (input valid, input req_type, input pixel_in, output ready);
endinterface

interface ipu_out_if;
	logic        valid;
	logic        ready;
	logic        kind;
	logic [23:0] pixel_out;
	logic [1:0]  pad_bytes;
	logic        row_last;
	logic        image_last;

	modport source (output valid, output kind, output pixel_out, output pad_bytes,
		output row_last, output image_last, input ready);
	modport sink   (input valid, input kind, input pixel_out, input pad_bytes,
		input row_last, input image_last, output ready);
endinterface

// ===== sv/ipu_ram.sv =====
// ----------------------------------------------------------------------------
// ipu_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module ipu_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 1024,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		// Hold read data until the next read
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== sv/ipu_cfg.sv =====
// ----------------------------------------------------------------------------
// ipu_cfg
// APB register file; clamps settings and derives the row padding count.
// ----------------------------------------------------------------------------
module ipu_cfg import ipu_pkg::*; #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_FACTOR = 100
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready,
	output cfg_t              cfg
);

	localparam int WCAP = (MAX_WIDTH < 2047) ? MAX_WIDTH : 2047;
	localparam int FCAP = (MAX_FACTOR < 127) ? MAX_FACTOR : 127;

	logic [FACT_W-1:0] scale_q;
	logic [LEN_W-1:0]  width_q;
	logic [LEN_W-1:0]  rows_q;
	logic              wr_en;
	logic [1:0]        idx;
	logic [3:0]        pad_prod;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;
	assign idx    = paddr[3:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q <= FACT_W'(1);
			width_q <= LEN_W'(1);
			rows_q  <= LEN_W'(1);
		end else if (wr_en) begin
			unique case (idx)
				REG_SCALE: scale_q <= pwdata[FACT_W-1:0];
				REG_WIDTH: width_q <= pwdata[LEN_W-1:0];
				REG_ROWS:  rows_q  <= pwdata[LEN_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_SCALE: prdata = APB_DW'(scale_q);
			REG_WIDTH: prdata = APB_DW'(width_q);
			REG_ROWS:  prdata = APB_DW'(rows_q);
			default:   prdata = '0;
		endcase
	end

	// Zero acts as one; large values saturate at the build limits
	always_comb begin
		if (scale_q == '0) begin
			cfg.factor = FACT_W'(1);
		end else if (32'(scale_q) > FCAP) begin
			cfg.factor = FACT_W'(FCAP);
		end else begin
			cfg.factor = scale_q;
		end
		if (width_q == '0) begin
			cfg.width = LEN_W'(1);
		end else if (32'(width_q) > WCAP) begin
			cfg.width = LEN_W'(WCAP);
		end else begin
			cfg.width = width_q;
		end
		cfg.rows = (rows_q == '0) ? LEN_W'(1) : rows_q;
	end

	// (width * factor) mod 4 only needs the low two bits of each
	assign pad_prod    = {2'b00, cfg.width[1:0]} * {2'b00, cfg.factor[1:0]};
	assign cfg.pad     = pad_prod[PAD_W-1:0];
	assign cfg.restart = wr_en && ((idx == REG_SCALE) || (idx == REG_WIDTH) || (idx == REG_ROWS));

endmodule

// ===== sv/ipu_seq.sv =====
// ----------------------------------------------------------------------------
// ipu_seq
// Fill and replay sequencer around the line store, with the result stage.
// ----------------------------------------------------------------------------
module ipu_seq import ipu_pkg::*; #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_FACTOR = 100,
	localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1,
	localparam int FB = (MAX_FACTOR > 1) ? $clog2(MAX_FACTOR) : 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  cfg_t             cfg,
	ipu_in_if.sink           in_ch,
	ipu_out_if.source        out_ch,
	output logic             ram_we,
	output logic [AW-1:0]    ram_waddr,
	output logic [PIX_W-1:0] ram_wdata,
	output logic             ram_re,
	output logic [AW-1:0]    ram_raddr,
	input  logic [PIX_W-1:0] ram_rdata
);

	logic              replaying_q;
	logic [AW-1:0]     fill_q;
	logic [AW-1:0]     col_q;
	logic [FB-1:0]     hrep_q;
	logic [FB-1:0]     vrep_q;
	logic [LEN_W-1:0]  rows_q;

	logic              valid_s1;
	logic              kind_s1;
	logic [PAD_W-1:0]  pad_s1;
	logic              rlast_s1;
	logic              ilast_s1;

	logic acc, is_fill, is_refuse, is_pull;
	logic fill_done, h_done, c_done, v_done, r_done, row_end, img_end;

	assign in_ch.ready = !valid_s1 || out_ch.ready;
	assign acc         = in_ch.valid && in_ch.ready;
	assign is_fill     = acc && (in_ch.req_type == REQ_PIXEL) && !replaying_q;
	assign is_refuse   = acc && (in_ch.req_type == REQ_PIXEL) && replaying_q;
	assign is_pull     = acc && (in_ch.req_type == REQ_PULL) && replaying_q;

	assign fill_done = (32'(fill_q) + 32'd1) >= 32'(cfg.width);
	assign h_done    = (32'(hrep_q) + 32'd1) >= 32'(cfg.factor);
	assign c_done    = (32'(col_q) + 32'd1) >= 32'(cfg.width);
	assign v_done    = (32'(vrep_q) + 32'd1) >= 32'(cfg.factor);
	assign r_done    = (32'(rows_q) + 32'd1) >= 32'(cfg.rows);
	assign row_end   = h_done && c_done;
	assign img_end   = row_end && v_done && r_done;

	assign ram_we    = is_fill;
	assign ram_waddr = fill_q;
	assign ram_wdata = in_ch.pixel_in;
	assign ram_re    = is_pull;
	assign ram_raddr = col_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			replaying_q <= 1'b0;
			fill_q      <= '0;
			col_q       <= '0;
			hrep_q      <= '0;
			vrep_q      <= '0;
			rows_q      <= '0;
		end else begin
			priority if (cfg.restart) begin
				replaying_q <= 1'b0;
				fill_q      <= '0;
				col_q       <= '0;
				hrep_q      <= '0;
				vrep_q      <= '0;
				rows_q      <= '0;
			end else if (is_fill) begin
				if (fill_done) begin
					fill_q      <= '0;
					replaying_q <= 1'b1;
					col_q       <= '0;
					hrep_q      <= '0;
					vrep_q      <= '0;
				end else begin
					fill_q <= fill_q + AW'(1);
				end
			end else if (is_pull) begin
				if (!h_done) begin
					hrep_q <= hrep_q + FB'(1);
				end else begin
					hrep_q <= '0;
					if (!c_done) begin
						col_q <= col_q + AW'(1);
					end else begin
						col_q <= '0;
						if (!v_done) begin
							vrep_q <= vrep_q + FB'(1);
						end else begin
							vrep_q      <= '0;
							replaying_q <= 1'b0;
							rows_q      <= r_done ? '0 : rows_q + LEN_W'(1);
						end
					end
				end
			end else begin
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= is_refuse || is_pull;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.ready) begin
			kind_s1  <= is_refuse ? KIND_REFUSED : KIND_PIXEL;
			pad_s1   <= (is_pull && row_end) ? cfg.pad : '0;
			rlast_s1 <= is_pull && row_end;
			ilast_s1 <= is_pull && img_end;
		end
	end

	assign out_ch.valid      = valid_s1;
	assign out_ch.kind       = kind_s1;
	assign out_ch.pixel_out  = (kind_s1 == KIND_REFUSED) ? '0 : ram_rdata;
	assign out_ch.pad_bytes  = pad_s1;
	assign out_ch.row_last   = rlast_s1;
	assign out_ch.image_last = ilast_s1;

endmodule

// ===== sv/integer_pixel_upscaler.sv =====
// ----------------------------------------------------------------------------
// integer_pixel_upscaler
// Results: each result beat is registered and appears in the cycle after its request beat is accepted.
// Throughput: one request beat per cycle, set by the single line store read
//   port; a stalled result holds the pipe until the sink takes it.
// Reset: asynchronous, active low; settings return to 1, counters to zero;
//   the line store holds no reset and is always written before it is read.
// ----------------------------------------------------------------------------
module integer_pixel_upscaler import ipu_pkg::*; #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_FACTOR = 100
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready,
	ipu_in_if.sink            in_ch,
	ipu_out_if.source         out_ch
);

	localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

	cfg_t             cfg;
	logic             ram_we;
	logic [AW-1:0]    ram_waddr;
	logic [PIX_W-1:0] ram_wdata;
	logic             ram_re;
	logic [AW-1:0]    ram_raddr;
	logic [PIX_W-1:0] ram_rdata;

	// Settings: clamp out-of-range values and restart the image on any write to the scale, width or rows register
	ipu_cfg #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_FACTOR (MAX_FACTOR)
	) u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Sequencer: pixel beats fill the line store; once a row is complete,
	// pull beats read it back column by column, repeating each column
	// factor times and the whole row factor times. Pixel beats that land
	// during replay come back as refused beats. The read data lands in the
	// RAM output register, which doubles as the result register.
	ipu_seq #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_FACTOR (MAX_FACTOR)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_ch     (in_ch),
		.out_ch    (out_ch),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata),
		.ram_re    (ram_re),
		.ram_raddr (ram_raddr),
		.ram_rdata (ram_rdata)
	);

	// Line store: one input row, written during fill, read during replay.
	// Fill and replay never overlap, so no forwarding path is needed.
	ipu_ram #(
		.WIDTH (PIX_W),
		.DEPTH (MAX_WIDTH)
	) u_line_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

endmodule

// ===== verif/upscale_monitor.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// upscale_monitor
// Watches the register port and both beat channels, keeps a running model of
// the line store and replay counters, and compares every result beat with the
// oldest predicted one.
// ----------------------------------------------------------------------------
module upscale_monitor import ipu_pkg::*; #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_FACTOR = 100
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic              pready,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	ipu_in_if                 in_mon,
	ipu_out_if                out_mon,
	output int                fail_count,
	output int                pending,
	output int                pixels_seen,
	output int                refusals_seen,
	output int                images_seen
);

	typedef struct {
		kind_t            kind;
		logic [PIX_W-1:0] pixel;
		logic [PAD_W-1:0] pad;
		logic             row_end;
		logic             image_end;
	} beat_t;

	beat_t             upscaled_beats[$];
	logic [PIX_W-1:0]  row_buf [MAX_WIDTH];
	logic [FACT_W-1:0] scale_reg;
	logic [LEN_W-1:0]  width_reg;
	logic [LEN_W-1:0]  rows_reg;
	logic [LEN_W-1:0]  fill_pos;
	logic [LEN_W-1:0]  col;
	logic [FACT_W-1:0] hcount;
	logic [FACT_W-1:0] vcount;
	logic [LEN_W-1:0]  rows_out;
	logic              replay;

	function automatic void restart_image();
		fill_pos = '0;
		replay   = 1'b0;
		col      = '0;
		hcount   = '0;
		vcount   = '0;
		rows_out = '0;
	endfunction

	function automatic void report_field(string field, logic [31:0] want, logic [31:0] got);
		$display("%0t: %s expected %0h actual %0h", $time, field, want, got);
		fail_count++;
	endfunction

	// Advance the model by one request beat; push the result beat it causes, if any.
	function automatic void predict_upscale(req_t req, logic [PIX_W-1:0] pix);
		int    f;
		int    w;
		int    r;
		beat_t b;
		f = (scale_reg == 0) ? 1 : (scale_reg > MAX_FACTOR) ? MAX_FACTOR : int'(scale_reg);
		w = (width_reg == 0) ? 1 : (width_reg > MAX_WIDTH) ? MAX_WIDTH : int'(width_reg);
		r = (rows_reg == 0) ? 1 : int'(rows_reg);
		b.kind      = KIND_PIXEL;
		b.pixel     = '0;
		b.pad       = '0;
		b.row_end   = 1'b0;
		b.image_end = 1'b0;
		if (req == REQ_PIXEL) begin
			if (replay) begin
				b.kind = KIND_REFUSED;
				upscaled_beats.push_back(b);
				return;
			end
			row_buf[fill_pos] = pix;
			fill_pos++;
			if (fill_pos >= w) begin
				fill_pos = '0;
				replay   = 1'b1;
				col      = '0;
				hcount   = '0;
				vcount   = '0;
			end
			return;
		end
		// a pull during the fill is dropped
		if (!replay)
			return;
		b.pixel = row_buf[col];
		hcount++;
		if (hcount >= f) begin
			hcount = '0;
			col++;
			if (col >= w) begin
				col       = '0;
				b.row_end = 1'b1;
				b.pad     = PAD_W'(w * f);
				vcount++;
				if (vcount >= f) begin
					vcount = '0;
					replay = 1'b0;
					rows_out++;
					if (rows_out >= r) begin
						rows_out    = '0;
						b.image_end = 1'b1;
					end
				end
			end
		end
		upscaled_beats.push_back(b);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		beat_t want;
		if (!arst_n) begin
			upscaled_beats.delete();
			scale_reg = 1;
			width_reg = 1;
			rows_reg  = 1;
			restart_image();
			fail_count    = 0;
			pixels_seen   = 0;
			refusals_seen = 0;
			images_seen   = 0;
			pending <= 0;
		end else begin
			if (out_mon.valid && out_mon.ready) begin
				if (upscaled_beats.size() == 0) begin
					$display("%0t: unexpected result beat kind %0h pixel %0h", $time,
						out_mon.kind, out_mon.pixel_out);
					fail_count++;
				end else begin
					want = upscaled_beats.pop_front();
					if (out_mon.kind !== want.kind)
						report_field("kind", want.kind, out_mon.kind);
					if (out_mon.pixel_out !== want.pixel)
						report_field("pixel_out", want.pixel, out_mon.pixel_out);
					if (out_mon.pad_bytes !== want.pad)
						report_field("pad_bytes", want.pad, out_mon.pad_bytes);
					if (out_mon.row_last !== want.row_end)
						report_field("row_last", want.row_end, out_mon.row_last);
					if (out_mon.image_last !== want.image_end)
						report_field("image_last", want.image_end, out_mon.image_last);
					if (want.kind == KIND_REFUSED)
						refusals_seen++;
					else
						pixels_seen++;
					if (want.image_end)
						images_seen++;
				end
			end
			if (psel && penable && pwrite && pready) begin
				case (reg_idx_t'(paddr[3:2]))
					REG_SCALE: begin
						scale_reg = pwdata[FACT_W-1:0];
						restart_image();
					end
					REG_WIDTH: begin
						width_reg = pwdata[LEN_W-1:0];
						restart_image();
					end
					REG_ROWS: begin
						rows_reg = pwdata[LEN_W-1:0];
						restart_image();
					end
					default: ;
				endcase
			end
			if (in_mon.valid && in_mon.ready)
				predict_upscale(req_t'(in_mon.req_type), in_mon.pixel_in);
			pending <= upscaled_beats.size();
		end
	end

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives the integer pixel upscaler through a series of image settings, from
// the clamped extremes to small random ones, feeding mostly complete rows with
// random pixels plus stray pulls and refused pixels, under changing amounts of
// idling on both channels. A monitor beside the block checks every result.
// ----------------------------------------------------------------------------
module testbench;
	import ipu_pkg::*;

	localparam int WIDTH_CAP   = 1024;
	localparam int FACTOR_CAP  = 100;
	localparam int HOLD_CYCLES = 300;

	typedef enum int {
		IDLE_NONE,
		IDLE_SENDER,
		IDLE_RECEIVER,
		IDLE_BOTH
	} idle_mode_t;

	logic              clk     = 1'b0;
	logic              arst_n  = 1'b0;
	logic              psel    = 1'b0;
	logic              penable = 1'b0;
	logic              pwrite  = 1'b0;
	logic [APB_AW-1:0] paddr   = '0;
	logic [APB_DW-1:0] pwdata  = '0;
	logic [APB_DW-1:0] prdata;
	logic              pready;

	// Source side of the request channel and sink side of the result channel
	logic              send_valid = 1'b0;
	logic              send_req   = 1'b0;
	logic [PIX_W-1:0]  send_pix   = '0;
	logic              sink_ready = 1'b0;

	ipu_in_if  in_ch ();
	ipu_out_if out_ch ();

	assign in_ch.valid    = send_valid;
	assign in_ch.req_type = send_req;
	assign in_ch.pixel_in = send_pix;
	assign out_ch.ready   = sink_ready;

	int fail_count;
	int pending;
	int pixels_seen;
	int refusals_seen;
	int images_seen;

	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	int hold_req       = 0;
	int hold_seen      = 0;
	int hold_left      = 0;
	int beats_sent     = 0;
	int eff_f          = 1;
	int eff_w          = 1;

	integer_pixel_upscaler #(
		.MAX_WIDTH  (WIDTH_CAP),
		.MAX_FACTOR (FACTOR_CAP)
	) u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.in_ch   (in_ch),
		.out_ch  (out_ch)
	);

	upscale_monitor #(
		.MAX_WIDTH  (WIDTH_CAP),
		.MAX_FACTOR (FACTOR_CAP)
	) u_monitor (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.pready        (pready),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.in_mon        (in_ch),
		.out_mon       (out_ch),
		.fail_count    (fail_count),
		.pending       (pending),
		.pixels_seen   (pixels_seen),
		.refusals_seen (refusals_seen),
		.images_seen   (images_seen)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Result sink: a new hold request from the stimulus starts a long hold-off,
	// counted here; otherwise stall at random at the current rate.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sink_ready <= 1'b0;
			hold_seen  <= 0;
			hold_left  <= 0;
		end else if (hold_seen != hold_req) begin
			hold_seen  <= hold_req;
			hold_left  <= HOLD_CYCLES;
			sink_ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left  <= hold_left - 1;
			sink_ready <= 1'b0;
		end else begin
			sink_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	task automatic set_idling(idle_mode_t mode);
		case (mode)
			IDLE_NONE: begin
				send_idle_pct  = 0;
				recv_stall_pct = 0;
			end
			IDLE_SENDER: begin
				send_idle_pct  = 53;
				recv_stall_pct = 0;
			end
			IDLE_RECEIVER: begin
				send_idle_pct  = 0;
				recv_stall_pct = 53;
			end
			default: begin
				send_idle_pct  = 26;
				recv_stall_pct = 26;
			end
		endcase
	endtask

	// Offer one request beat and hold it until the block takes it. Called at a
	// rising edge; returns at the edge that accepted the beat with valid still
	// high, so back-to-back beats never drop valid.
	task automatic send_beat(req_t req, logic [PIX_W-1:0] pix);
		while ($urandom_range(99) < send_idle_pct) begin
			send_valid <= 1'b0;
			@(posedge clk);
		end
		send_valid <= 1'b1;
		send_req   <= req;
		send_pix   <= pix;
		@(posedge clk);
		while (!in_ch.ready)
			@(posedge clk);
		beats_sent++;
	endtask

	// Drop valid and wait until every predicted result has been taken, then let
	// the clock run on in case the last beat was a pull that gives nothing.
	task automatic drain();
		send_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(reg_idx_t idx, logic [APB_DW-1:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// Reprogram all three registers on an idle block; keep the clamped factor
	// and width for shaping rows.
	task automatic setup_image(int scale, int width, int rows);
		drain();
		write_reg(REG_ROWS, rows);
		write_reg(REG_WIDTH, width);
		write_reg(REG_SCALE, scale);
		eff_f = (scale == 0) ? 1 : (scale > FACTOR_CAP) ? FACTOR_CAP : scale;
		eff_w = (width == 0) ? 1 : (width > WIDTH_CAP) ? WIDTH_CAP : width;
	endtask

	// Feed whole rows: fill the line store, then pull the full replay. With
	// noise, slip in pulls during the fill (dropped) and pixels during the
	// replay (refused). The last row may be cut short by the next setup.
	task automatic stream_rows(int items, int noise_pct);
		int sent;
		sent = 0;
		while (sent < items) begin
			for (int i = 0; i < eff_w && sent < items; i++) begin
				if ($urandom_range(99) < noise_pct)
					send_beat(REQ_PULL, $urandom);
				send_beat(REQ_PIXEL, $urandom);
				sent++;
			end
			for (int k = 0; k < eff_w * eff_f * eff_f && sent < items; k++) begin
				if ($urandom_range(99) < noise_pct) begin
					send_beat(REQ_PIXEL, $urandom);
					sent++;
				end
				send_beat(REQ_PULL, $urandom);
				sent++;
			end
		end
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: reset settings give one pixel per row and per image.
		set_idling(IDLE_NONE);
		send_beat(REQ_PULL, 24'hFFFFFF);    // pull while filling: dropped
		send_beat(REQ_PIXEL, 24'h000000);   // completes the row
		send_beat(REQ_PIXEL, 24'hFFFFFF);   // refused during replay
		send_beat(REQ_PULL, 24'h000000);    // row end, image end, pad of one
		send_beat(REQ_PIXEL, 24'hFFFFFF);
		send_beat(REQ_PULL, 24'hFFFFFF);

		// Zero in every register acts as one.
		setup_image(0, 0, 0);
		send_beat(REQ_PIXEL, 24'h5AA55A);
		send_beat(REQ_PIXEL, 24'hA55AA5);
		send_beat(REQ_PULL, 24'h000000);
		send_beat(REQ_PULL, 24'h000000);    // filling again: dropped

		// Small images, pad of three and of two, several image ends.
		setup_image(3, 5, 2);
		set_idling(IDLE_SENDER);
		stream_rows(120, 10);
		setup_image(0, 0, 0);
		set_idling(IDLE_RECEIVER);
		stream_rows(40, 10);
		setup_image(2, 7, 3);
		set_idling(IDLE_BOTH);
		stream_rows(100, 10);

		// Extremes: start a row at the capped width, run the first output rows
		// at the capped factor, then the tallest image.
		setup_image(1, 2047, 1);
		set_idling(IDLE_NONE);
		stream_rows(60, 0);
		setup_image(127, 1, 2);
		set_idling(IDLE_RECEIVER);
		stream_rows(1 + 2 * FACTOR_CAP + FACTOR_CAP / 2, 0);
		setup_image(1, 3, 2047);
		set_idling(IDLE_SENDER);
		stream_rows(30, 10);

		// Back-pressure: hold the sink off while requests keep coming.
		setup_image(2, 4, 2);
		set_idling(IDLE_NONE);
		hold_req++;
		stream_rows(120, 10);

		// Random small settings under random idling.
		repeat (5) begin
			setup_image($urandom_range(4, 1), $urandom_range(12, 1), $urandom_range(4, 1));
			set_idling(idle_mode_t'($urandom_range(3)));
			stream_rows(16, 15);
		end

		drain();
		repeat (8) @(posedge clk);

		$display("Sent %0d request beats over 13 image settings, idling and hold-off.",
			beats_sent);
		$display("Checked %0d output pixels, %0d refused beats, %0d image ends.",
			pixels_seen, refusals_seen, images_seen);
		if (fail_count == 0) begin
			$display("integer_pixel_upscaler: match");
		end else begin
			$display("integer_pixel_upscaler: mismatch");
		end
		$finish;
	end

	// Watchdog: well beyond the slowest correct run.
	initial begin
		#2_000_000;
		$display("Timed out with %0d results outstanding.", pending);
		$display("integer_pixel_upscaler: mismatch");
		$finish;
	end

endmodule
